FILE: src/asp_pkg.sv
// Package for the SGR escape sequence parser.
// Holds the character codes, status codes, attribute masks and result type.
// No dependencies.
package asp_pkg;

    // Character codes recognised by the parser.
    localparam logic [7:0] ChEsc   = 8'h1B;
    localparam logic [7:0] ChLbr   = 8'h5B;
    localparam logic [7:0] ChSemi  = 8'h3B;
    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChFinal = 8'h6D;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;

    // Parameter values saturate here.
    localparam logic [7:0] ParamMax = 8'd255;

    // Style bit masks.
    localparam logic [5:0] StBold      = 6'h01;
    localparam logic [5:0] StItalic    = 6'h02;
    localparam logic [5:0] StUnderline = 6'h04;
    localparam logic [5:0] StBlink     = 6'h08;
    localparam logic [5:0] StReverse   = 6'h10;
    localparam logic [5:0] StFrame     = 6'h20;
    localparam logic [5:0] StAll       = 6'h3F;

    // Colour mode masks.
    localparam logic [3:0] CmFgDef = 4'h1;
    localparam logic [3:0] CmBgDef = 4'h2;
    localparam logic [3:0] CmFgIdx = 4'h4;
    localparam logic [3:0] CmBgIdx = 4'h8;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_DONE    = 2'd1,
        ST_REJECT  = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [5:0] add_flags;
        logic [5:0] remove_flags;
        logic [3:0] color_flags;
        logic [3:0] fg_index;
        logic [3:0] bg_index;
    } t_result;

endpackage

FILE: src/asp_in_if.sv
// Input channel of the SGR escape sequence parser: one character per item.
// Depends on nothing.
interface asp_in_if;
    logic       valid;
    logic       ready;
    logic       restart;
    logic [7:0] ch;

    modport source (output valid, output restart, output ch, input ready);
    modport sink (input valid, input restart, input ch, output ready);
endinterface

FILE: src/asp_out_if.sv
// Result channel of the SGR escape sequence parser: status and attributes.
// Depends on nothing.
interface asp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] add_flags;
    logic [5:0] remove_flags;
    logic [3:0] color_flags;
    logic [3:0] fg_index;
    logic [3:0] bg_index;

    modport source (output valid, output status, output add_flags, output remove_flags,
                    output color_flags, output fg_index, output bg_index, input ready);
    modport sink (input valid, input status, input add_flags, input remove_flags,
                  input color_flags, input fg_index, input bg_index, output ready);
endinterface

FILE: src/ansi_sgr_escape_parser.sv
// SGR escape sequence parser, top level.
// Depends on asp_pkg, asp_in_if and asp_out_if.
//
// Usage:
//   i_in carries one character byte per item, with a restart bit that clears
//   the parser and the collected attributes before that byte is handled.
//   o_out carries exactly one result item per input item, in order: a status
//   and the attribute state (styles to add and remove, colour flags and the
//   16-colour indices) as it stands after the byte.
//   Each result is registered in the output or skid register. Throughput is
//   one item per cycle while input ready is high; the parser state is updated
//   at the accepting edge, so a byte may follow in the very next cycle.
//   The result side has an output register and a one-item skid register.
//   When the receiver stalls, the output register holds and one further item
//   is taken into the skid register; input ready then falls until the
//   receiver drains it. Input ready comes straight from a register.
//   After reset the parser waits for ESC with all attributes zero, both
//   result registers are empty and input ready is high.
module ansi_sgr_escape_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    asp_in_if.sink    i_in,
    asp_out_if.source o_out
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_NUM  = 2'd2,
        PH_END  = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase, e_phase;
    logic [7:0] r_param, n_param, e_param;
    logic [5:0] r_set, n_set, e_set;
    logic [5:0] r_clr, n_clr, e_clr;
    logic [3:0] r_cmode, n_cmode, e_cmode;
    logic [3:0] r_fg, n_fg, e_fg;
    logic [3:0] r_bg, n_bg, e_bg;

    asp_pkg::t_result r_out, n_out;
    asp_pkg::t_result r_skid, n_skid;
    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;

    asp_pkg::t_status step_status;
    asp_pkg::t_result step_res;

    logic       in_acc;
    logic       out_free;
    logic [3:0] digit;
    logic [11:0] param_acc;

    // Result of applying the finished parameter.
    logic       ap_ok;
    logic [5:0] ap_set;
    logic [5:0] ap_clr;
    logic [3:0] ap_cmode;
    logic [3:0] ap_fg;
    logic [3:0] ap_bg;
    logic [7:0] fg_lo, fg_hi, bg_lo, bg_hi;

    assign i_in.ready = !r_skid_valid;
    assign in_acc     = i_in.valid && !r_skid_valid;
    assign out_free   = !r_out_valid || o_out.ready;

    // A restart clears everything before the byte is looked at.
    always_comb begin
        if (i_in.restart) begin
            e_phase = PH_IDLE;
            e_param = '0;
            e_set   = '0;
            e_clr   = '0;
            e_cmode = '0;
            e_fg    = '0;
            e_bg    = '0;
        end else begin
            e_phase = r_phase;
            e_param = r_param;
            e_set   = r_set;
            e_clr   = r_clr;
            e_cmode = r_cmode;
            e_fg    = r_fg;
            e_bg    = r_bg;
        end
    end

    assign digit     = 4'(i_in.ch - asp_pkg::ChZero);
    assign param_acc = {1'b0, e_param, 3'b000} + {3'b000, e_param, 1'b0} + {8'd0, digit};

    assign fg_lo = e_param - 8'd30;
    assign fg_hi = e_param - 8'd82;
    assign bg_lo = e_param - 8'd40;
    assign bg_hi = e_param - 8'd92;

    always_comb begin
        ap_ok    = 1'b1;
        ap_set   = e_set;
        ap_clr   = e_clr;
        ap_cmode = e_cmode;
        ap_fg    = e_fg;
        ap_bg    = e_bg;
        case (e_param)
            8'd0: begin
                ap_set   = '0;
                ap_clr   = asp_pkg::StAll;
                ap_cmode = asp_pkg::CmFgDef | asp_pkg::CmBgDef;
            end
            8'd1:  ap_set = e_set | asp_pkg::StBold;
            8'd3:  ap_set = e_set | asp_pkg::StItalic;
            8'd4:  ap_set = e_set | asp_pkg::StUnderline;
            8'd5:  ap_set = e_set | asp_pkg::StBlink;
            8'd7:  ap_set = e_set | asp_pkg::StReverse;
            8'd51: ap_set = e_set | asp_pkg::StFrame;
            8'd21, 8'd22: ap_clr = e_clr | asp_pkg::StBold;
            8'd23: ap_clr = e_clr | asp_pkg::StItalic;
            8'd24: ap_clr = e_clr | asp_pkg::StUnderline;
            8'd25: ap_clr = e_clr | asp_pkg::StBlink;
            8'd27: ap_clr = e_clr | asp_pkg::StReverse;
            8'd54: ap_clr = e_clr | asp_pkg::StFrame;
            8'd38, 8'd48: begin
                // Extended colour selectors are taken but have no effect.
            end
            8'd39: ap_cmode = e_cmode | asp_pkg::CmFgDef;
            8'd49: ap_cmode = e_cmode | asp_pkg::CmBgDef;
            default: begin
                if (e_param >= 8'd30 && e_param <= 8'd37) begin
                    ap_fg    = fg_lo[3:0];
                    ap_cmode = (e_cmode | asp_pkg::CmFgIdx) & ~asp_pkg::CmFgDef;
                end else if (e_param >= 8'd90 && e_param <= 8'd97) begin
                    ap_fg    = fg_hi[3:0];
                    ap_cmode = (e_cmode | asp_pkg::CmFgIdx) & ~asp_pkg::CmFgDef;
                end else if (e_param >= 8'd40 && e_param <= 8'd47) begin
                    ap_bg    = bg_lo[3:0];
                    ap_cmode = (e_cmode | asp_pkg::CmBgIdx) & ~asp_pkg::CmBgDef;
                end else if (e_param >= 8'd100 && e_param <= 8'd107) begin
                    ap_bg    = bg_hi[3:0];
                    ap_cmode = (e_cmode | asp_pkg::CmBgIdx) & ~asp_pkg::CmBgDef;
                end else begin
                    ap_ok = 1'b0;
                end
            end
        endcase
    end

    // Next parser state and the status of this byte.
    always_comb begin
        n_phase     = e_phase;
        n_param     = e_param;
        n_set       = e_set;
        n_clr       = e_clr;
        n_cmode     = e_cmode;
        n_fg        = e_fg;
        n_bg        = e_bg;
        step_status = asp_pkg::ST_PENDING;
        case (e_phase)
            PH_IDLE: begin
                if (i_in.ch == asp_pkg::ChEsc) begin
                    n_phase = PH_ESC;
                end else begin
                    step_status = asp_pkg::ST_REJECT;
                end
            end
            PH_ESC: begin
                if (i_in.ch == asp_pkg::ChLbr) begin
                    n_phase = PH_NUM;
                end else begin
                    n_phase     = PH_IDLE;
                    step_status = asp_pkg::ST_REJECT;
                end
            end
            PH_NUM: begin
                if (i_in.ch >= asp_pkg::ChZero && i_in.ch <= asp_pkg::ChNine) begin
                    n_param = (param_acc > {4'd0, asp_pkg::ParamMax}) ? asp_pkg::ParamMax
                                                                     : param_acc[7:0];
                end else if ((i_in.ch == asp_pkg::ChSemi || i_in.ch == asp_pkg::ChColon ||
                              i_in.ch == asp_pkg::ChFinal) && ap_ok) begin
                    n_param = '0;
                    n_set   = ap_set;
                    n_clr   = ap_clr;
                    n_cmode = ap_cmode;
                    n_fg    = ap_fg;
                    n_bg    = ap_bg;
                    if (i_in.ch == asp_pkg::ChFinal) begin
                        n_phase     = PH_END;
                        step_status = asp_pkg::ST_DONE;
                    end
                end else begin
                    step_status = asp_pkg::ST_REJECT;
                end
            end
            default: begin
                step_status = asp_pkg::ST_IGNORED;
            end
        endcase
        // A rejected sequence leaves nothing behind.
        if (step_status == asp_pkg::ST_REJECT) begin
            n_phase = PH_IDLE;
            n_param = '0;
            n_set   = '0;
            n_clr   = '0;
            n_cmode = '0;
            n_fg    = '0;
            n_bg    = '0;
        end
    end

    always_comb begin
        step_res.status       = step_status;
        step_res.add_flags    = n_set;
        step_res.remove_flags = n_clr;
        step_res.color_flags  = n_cmode;
        step_res.fg_index     = n_fg;
        step_res.bg_index     = n_bg;
    end

    // Output register with a one-item skid register behind it.
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (out_free) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (in_acc) begin
            if (out_free) begin
                n_out       = step_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = step_res;
                n_skid_valid = 1'b1;
            end
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_param      <= '0;
            r_set        <= '0;
            r_clr        <= '0;
            r_cmode      <= '0;
            r_fg         <= '0;
            r_bg         <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_param <= n_param;
                r_set   <= n_set;
                r_clr   <= n_clr;
                r_cmode <= n_cmode;
                r_fg    <= n_fg;
                r_bg    <= n_bg;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.add_flags    = r_out.add_flags;
    assign o_out.remove_flags = r_out.remove_flags;
    assign o_out.color_flags  = r_out.color_flags;
    assign o_out.fg_index     = r_out.fg_index;
    assign o_out.bg_index     = r_out.bg_index;

endmodule

FILE: src/asp_checker.sv
// Port-level checks for the SGR escape sequence parser.
// Depends on asp_pkg; bound to ansi_sgr_escape_parser at the end of this file.
module asp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [5:0] i_add_flags,
    input logic [5:0] i_remove_flags,
    input logic [3:0] i_color_flags,
    input logic [3:0] i_fg_index,
    input logic [3:0] i_bg_index
);

    logic        r_have_last;
    logic [1:0]  r_last_status;
    logic [23:0] r_last_attr;
    logic [23:0] cur_attr;
    logic        out_acc;

    assign cur_attr = {i_add_flags, i_remove_flags, i_color_flags, i_fg_index, i_bg_index};
    assign out_acc  = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
        end else if (out_acc) begin
            r_have_last <= 1'b1;
        end
        if (out_acc) begin
            r_last_status <= i_status;
            r_last_attr   <= cur_attr;
        end
    end

    // Reset empties the result side and opens the input.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("result pending or input closed after reset");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) && $stable(cur_attr))
        else $error("stalled result changed");

    // A rejection clears every attribute.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == asp_pkg::ST_REJECT |-> cur_attr == '0)
        else $error("rejected item carries attributes");

    // The end phase is only reached through a complete sequence and changes nothing.
    a_ignored_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == asp_pkg::ST_IGNORED |->
            r_have_last && cur_attr == r_last_attr &&
            (r_last_status == asp_pkg::ST_DONE || r_last_status == asp_pkg::ST_IGNORED))
        else $error("ignored item does not follow a complete sequence");

endmodule

bind ansi_sgr_escape_parser asp_checker u_asp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_add_flags    (o_out.add_flags),
    .i_remove_flags (o_out.remove_flags),
    .i_color_flags  (o_out.color_flags),
    .i_fg_index     (o_out.fg_index),
    .i_bg_index     (o_out.bg_index)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SGR escape sequence parser.
// Depends on asp_pkg, asp_in_if, asp_out_if and ansi_sgr_escape_parser.
module tb_top;

    // Select-graphic-rendition codes that the parser acts on.
    localparam int SgrReset        = 0;
    localparam int SgrBold         = 1;
    localparam int SgrItalic       = 3;
    localparam int SgrUnderline    = 4;
    localparam int SgrBlink        = 5;
    localparam int SgrReverse      = 7;
    localparam int SgrBoldOffAlt   = 21;
    localparam int SgrBoldOff      = 22;
    localparam int SgrItalicOff    = 23;
    localparam int SgrUnderlineOff = 24;
    localparam int SgrBlinkOff     = 25;
    localparam int SgrReverseOff   = 27;
    localparam int SgrFgBase       = 30;
    localparam int SgrFgExtended   = 38;
    localparam int SgrFgDefault    = 39;
    localparam int SgrBgBase       = 40;
    localparam int SgrBgExtended   = 48;
    localparam int SgrBgDefault    = 49;
    localparam int SgrFrame        = 51;
    localparam int SgrFrameOff     = 54;
    localparam int SgrFgBrightBase = 90;
    localparam int SgrBgBrightBase = 100;
    localparam int EmptyParam      = -1;

    localparam int RandomItems  = 950;
    localparam int ClockPeriod  = 12;
    localparam int LongHold     = 90;
    localparam int TimeoutTicks = 250000;

    typedef enum logic [1:0] {
        ParseWait   = 2'd0,
        ParseEsc    = 2'd1,
        ParseParams = 2'd2,
        ParseDone   = 2'd3
    } t_parse_phase;

    typedef struct {
        logic       restart;
        logic [7:0] ch;
        int         gap;
        bit         drain_first;
    } t_sgr_char;

    logic i_clk;
    logic i_rst_n;

    asp_in_if  in_if ();
    asp_out_if out_if ();

    ansi_sgr_escape_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted parser state.
    t_parse_phase sgr_phase;
    logic [7:0]   param_acc;
    logic [5:0]   style_add;
    logic [5:0]   style_remove;
    logic [3:0]   colour_mode;
    logic [3:0]   fg_colour;
    logic [3:0]   bg_colour;

    t_sgr_char        pending_chars[$];
    asp_pkg::t_result expected_attrs[$];
    asp_pkg::t_result oldest_attrs;
    t_sgr_char        next_char;

    int  sgr_misc_codes [18] = '{SgrReset, SgrBold, SgrItalic, SgrUnderline, SgrBlink,
                                 SgrReverse, SgrFrame, SgrBoldOffAlt, SgrBoldOff,
                                 SgrItalicOff, SgrUnderlineOff, SgrBlinkOff, SgrReverseOff,
                                 SgrFrameOff, SgrFgExtended, SgrBgExtended, SgrFgDefault,
                                 SgrBgDefault};

    int  sent_count;
    int  received_count;
    int  fail_count;
    int  done_count;
    int  reject_count;
    int  ignored_count;
    int  tx_gap_left;
    int  rx_hold_left;
    bit  rx_long_done;
    bit  tx_drain_next;
    int  calm_from;
    int  calm_to;

    function automatic void clear_parse_state();
        sgr_phase    = ParseWait;
        param_acc    = '0;
        style_add    = '0;
        style_remove = '0;
        colour_mode  = '0;
        fg_colour    = '0;
        bg_colour    = '0;
    endfunction

    // Applies one finished parameter; returns 0 for an unsupported code.
    function automatic logic apply_sgr_code(input logic [7:0] code);
        logic ok;
        ok = 1'b1;
        if (code == SgrReset) begin
            style_add    = '0;
            style_remove = asp_pkg::StAll;
            colour_mode  = asp_pkg::CmFgDef | asp_pkg::CmBgDef;
        end else if (code == SgrBold) style_add |= asp_pkg::StBold;
        else if (code == SgrItalic) style_add |= asp_pkg::StItalic;
        else if (code == SgrUnderline) style_add |= asp_pkg::StUnderline;
        else if (code == SgrBlink) style_add |= asp_pkg::StBlink;
        else if (code == SgrReverse) style_add |= asp_pkg::StReverse;
        else if (code == SgrFrame) style_add |= asp_pkg::StFrame;
        else if (code == SgrBoldOffAlt || code == SgrBoldOff) style_remove |= asp_pkg::StBold;
        else if (code == SgrItalicOff) style_remove |= asp_pkg::StItalic;
        else if (code == SgrUnderlineOff) style_remove |= asp_pkg::StUnderline;
        else if (code == SgrBlinkOff) style_remove |= asp_pkg::StBlink;
        else if (code == SgrReverseOff) style_remove |= asp_pkg::StReverse;
        else if (code == SgrFrameOff) style_remove |= asp_pkg::StFrame;
        else if (code >= SgrFgBase && code <= SgrFgBase + 7) begin
            fg_colour   = 4'(code - SgrFgBase);
            colour_mode = (colour_mode | asp_pkg::CmFgIdx) & ~asp_pkg::CmFgDef;
        end else if (code >= SgrFgBrightBase && code <= SgrFgBrightBase + 7) begin
            fg_colour   = 4'(code - SgrFgBrightBase + 8);
            colour_mode = (colour_mode | asp_pkg::CmFgIdx) & ~asp_pkg::CmFgDef;
        end else if (code >= SgrBgBase && code <= SgrBgBase + 7) begin
            bg_colour   = 4'(code - SgrBgBase);
            colour_mode = (colour_mode | asp_pkg::CmBgIdx) & ~asp_pkg::CmBgDef;
        end else if (code >= SgrBgBrightBase && code <= SgrBgBrightBase + 7) begin
            bg_colour   = 4'(code - SgrBgBrightBase + 8);
            colour_mode = (colour_mode | asp_pkg::CmBgIdx) & ~asp_pkg::CmBgDef;
        end else if (code == SgrFgExtended || code == SgrBgExtended) begin
            // Extended colours are accepted but change nothing.
        end else if (code == SgrFgDefault) colour_mode |= asp_pkg::CmFgDef;
        else if (code == SgrBgDefault) colour_mode |= asp_pkg::CmBgDef;
        else ok = 1'b0;
        param_acc = '0;
        return ok;
    endfunction

    function automatic asp_pkg::t_result predict_sgr(input logic restart,
                                                     input logic [7:0] ch);
        asp_pkg::t_status st;
        asp_pkg::t_result r;
        int               acc;
        st = asp_pkg::ST_PENDING;
        if (restart) clear_parse_state();
        case (sgr_phase)
            ParseWait: begin
                if (ch == asp_pkg::ChEsc) sgr_phase = ParseEsc;
                else begin
                    clear_parse_state();
                    st = asp_pkg::ST_REJECT;
                end
            end
            ParseEsc: begin
                if (ch == asp_pkg::ChLbr) sgr_phase = ParseParams;
                else begin
                    clear_parse_state();
                    st = asp_pkg::ST_REJECT;
                end
            end
            ParseParams: begin
                if (ch >= asp_pkg::ChZero && ch <= asp_pkg::ChNine) begin
                    acc = int'(param_acc) * 10 + int'(ch - asp_pkg::ChZero);
                    param_acc = (acc > int'(asp_pkg::ParamMax)) ? asp_pkg::ParamMax
                                                                : 8'(acc);
                end else if (ch == asp_pkg::ChSemi || ch == asp_pkg::ChColon) begin
                    if (!apply_sgr_code(param_acc)) begin
                        clear_parse_state();
                        st = asp_pkg::ST_REJECT;
                    end
                end else if (ch == asp_pkg::ChFinal) begin
                    if (apply_sgr_code(param_acc)) begin
                        sgr_phase = ParseDone;
                        st = asp_pkg::ST_DONE;
                    end else begin
                        clear_parse_state();
                        st = asp_pkg::ST_REJECT;
                    end
                end else begin
                    clear_parse_state();
                    st = asp_pkg::ST_REJECT;
                end
            end
            default: st = asp_pkg::ST_IGNORED;
        endcase
        r.status       = st;
        r.add_flags    = style_add;
        r.remove_flags = style_remove;
        r.color_flags  = colour_mode;
        r.fg_index     = fg_colour;
        r.bg_index     = bg_colour;
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp, input int act);
        if (exp != act) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp, act);
            fail_count++;
        end
    endfunction

    task automatic queue_char(input logic restart, input logic [7:0] ch);
        t_sgr_char c;
        int        idx;
        idx = pending_chars.size();
        c.restart     = restart;
        c.ch          = ch;
        c.drain_first = tx_drain_next;
        // Some stretches run back to back, one of them while the receiver holds off.
        if ((idx / 150) % 3 == 2 || (idx >= calm_from && idx < calm_to)) c.gap = 0;
        else c.gap = $urandom_range(0, 11);
        tx_drain_next = 1'b0;
        pending_chars = {pending_chars, c};
    endtask

    task automatic queue_param(input int value);
        string digits;
        if (value != EmptyParam) begin
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(1, 2) : 0)
                queue_char(1'b0, asp_pkg::ChZero);
            digits = $sformatf("%0d", value);
            for (int i = 0; i < digits.len(); i++) queue_char(1'b0, digits[i]);
        end
    endtask

    function automatic int pick_code();
        int pick;
        pick = $urandom_range(0, 12);
        if (pick <= 4) return sgr_misc_codes[$urandom_range(0, 17)];
        else if (pick == 5) return SgrFgBase + $urandom_range(0, 7);
        else if (pick == 6) return SgrFgBrightBase + $urandom_range(0, 7);
        else if (pick == 7) return SgrBgBase + $urandom_range(0, 7);
        else if (pick == 8) return SgrBgBrightBase + $urandom_range(0, 7);
        else if (pick == 9) return EmptyParam;
        else if (pick == 10) return $urandom_range(0, 255);
        else if (pick == 11) return $urandom_range(256, 99999);
        else return SgrReset;
    endfunction

    // A full sequence; a broken one carries one random byte among its parameters.
    task automatic queue_sgr_sequence(input logic with_restart, input bit broken);
        int n_params;
        int spoil_at;
        n_params = $urandom_range(1, 5);
        spoil_at = broken ? $urandom_range(0, n_params - 1) : -1;
        queue_char(with_restart, asp_pkg::ChEsc);
        queue_char(1'b0, asp_pkg::ChLbr);
        for (int i = 0; i < n_params; i++) begin
            if (i == spoil_at) queue_char(1'b0, 8'($urandom_range(0, 255)));
            queue_param(pick_code());
            if (i < n_params - 1)
                queue_char(1'b0, $urandom_range(0, 1) ? asp_pkg::ChSemi : asp_pkg::ChColon);
        end
        queue_char(1'b0, asp_pkg::ChFinal);
        repeat ($urandom_range(0, 2)) queue_char(1'($urandom_range(0, 1)),
                                                 8'($urandom_range(0, 255)));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #(ClockPeriod / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TimeoutTicks * ClockPeriod);
        $display("simulation failed");
        $finish;
    end

    // Sender: presents queued items and predicts the result of each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.restart <= 1'b0;
            in_if.ch      <= '0;
            tx_gap_left = 0;
            clear_parse_state();
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_attrs = {expected_attrs, predict_sgr(in_if.restart, in_if.ch)};
                sent_count++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pending_chars.size() > 0 &&
                             (!pending_chars[0].drain_first || sent_count == received_count)) begin
                    next_char = pending_chars.pop_front();
                    in_if.valid   <= 1'b1;
                    in_if.restart <= next_char.restart;
                    in_if.ch      <= next_char.ch;
                    tx_gap_left   = next_char.gap;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest prediction and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_hold_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_attrs.size() == 0) begin
                    $error("result item arrived with no prediction waiting");
                    fail_count++;
                end else begin
                    oldest_attrs = expected_attrs.pop_front();
                    check_field("status", int'(oldest_attrs.status), int'(out_if.status));
                    check_field("add_flags", oldest_attrs.add_flags, out_if.add_flags);
                    check_field("remove_flags", oldest_attrs.remove_flags,
                                out_if.remove_flags);
                    check_field("color_flags", oldest_attrs.color_flags, out_if.color_flags);
                    check_field("fg_index", oldest_attrs.fg_index, out_if.fg_index);
                    check_field("bg_index", oldest_attrs.bg_index, out_if.bg_index);
                end
                case (asp_pkg::t_status'(out_if.status))
                    asp_pkg::ST_DONE:    done_count++;
                    asp_pkg::ST_REJECT:  reject_count++;
                    asp_pkg::ST_IGNORED: ignored_count++;
                    default:             ;
                endcase
                received_count++;
                if ((received_count / 120) % 4 == 1) rx_hold_left = 0;
                else rx_hold_left = $urandom_range(0, 11);
                if (!rx_long_done && received_count >= 400) begin
                    rx_long_done = 1'b1;
                    rx_hold_left = LongHold;
                end
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int directed_count;
        int pick;
        i_rst_n        <= 1'b0;
        sent_count     = 0;
        received_count = 0;
        fail_count     = 0;
        done_count     = 0;
        reject_count   = 0;
        ignored_count  = 0;
        rx_long_done   = 1'b0;
        tx_drain_next  = 1'b0;
        calm_from      = 360;
        calm_to        = 560;
        clear_parse_state();

        // Empty parameter acts as a reset, then bytes in the end phase are ignored.
        queue_char(1'b1, asp_pkg::ChEsc);
        queue_char(1'b0, asp_pkg::ChLbr);
        queue_char(1'b0, asp_pkg::ChFinal);
        queue_char(1'b0, 8'hFF);
        queue_char(1'b0, 8'h00);
        // Brightest colours on both planes plus frame.
        queue_char(1'b1, asp_pkg::ChEsc);
        queue_char(1'b0, asp_pkg::ChLbr);
        queue_param(97);
        queue_char(1'b0, asp_pkg::ChColon);
        queue_param(107);
        queue_char(1'b0, asp_pkg::ChSemi);
        queue_param(SgrFrame);
        queue_char(1'b0, asp_pkg::ChFinal);
        // Stray byte while idle, then a wrong byte after ESC.
        queue_char(1'b1, 8'h00);
        queue_char(1'b0, asp_pkg::ChEsc);
        queue_char(1'b0, 8'h41);
        // Long parameter saturates and is rejected.
        queue_char(1'b0, asp_pkg::ChEsc);
        queue_char(1'b0, asp_pkg::ChLbr);
        queue_char(1'b0, asp_pkg::ChNine);
        queue_char(1'b0, asp_pkg::ChNine);
        queue_char(1'b0, asp_pkg::ChNine);
        queue_char(1'b0, asp_pkg::ChFinal);
        // High byte inside parameters, with a restart on the ESC.
        queue_char(1'b1, asp_pkg::ChEsc);
        queue_char(1'b0, asp_pkg::ChLbr);
        queue_char(1'b0, 8'h80);
        directed_count = pending_chars.size();

        tx_drain_next = 1'b1;
        while (pending_chars.size() < directed_count + RandomItems) begin
            if (pending_chars.size() > 600 && pending_chars.size() < 620) tx_drain_next = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick <= 6) queue_sgr_sequence($urandom_range(0, 7) != 0, 1'b0);
            else if (pick == 7) queue_sgr_sequence(1'b1, 1'b1);
            else if (pick == 8) begin
                repeat ($urandom_range(1, 4))
                    queue_char($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
            end else begin
                queue_char(1'b1, asp_pkg::ChEsc);
                queue_char(1'b0, 8'($urandom_range(0, 255)));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() > 0 || in_if.valid || sent_count != received_count)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_attrs.size() != 0) begin
            $error("%0d predicted results never arrived", expected_attrs.size());
            fail_count++;
        end

        $display("Sent %0d characters and checked %0d results.", sent_count, received_count);
        $display("Sequences completed %0d, rejected %0d, bytes ignored in end phase %0d.",
                 done_count, reject_count, ignored_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
